/* rtl/sfid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfid_pkg
// Shared types and constants for the smallest free identifier allocator.
// ----------------------------------------------------------------------------
package sfid_pkg;

    localparam int IDENT_W  = 16;
    localparam int STATUS_W = 3;

    typedef enum logic {
        CMD_TAKE   = 1'b0,
        CMD_RETURN = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN     = 3'd0,
        ST_RETURNED  = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_EXHAUSTED = 3'd4
    } t_status;

    typedef enum logic {
        HEAP_PUSH = 1'b0,
        HEAP_POP  = 1'b1
    } t_heap_op;

    typedef struct packed {
        logic     start;
        t_heap_op op;
    } t_heap_req;

    typedef struct packed {
        logic done;
        logic empty;
        logic full;
    } t_heap_rsp;

endpackage

/* rtl/smallest_free_id_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_free_id_allocator
// Hands out the lowest free identifier and takes identifiers back.
// ----------------------------------------------------------------------------
// One transaction at a time. A take served by the fresh counter, an exhausted
// take and any refused return pass through S_MAPRD, S_CHECK and S_OUT without
// the heap. A return that is kept waits in S_WAIT while the heap sifts up, one
// level per H_UP_CHK and H_UP_CMP pair. A take served from the heap waits
// while it sifts down, each level through H_DN_C, H_DN_L, the optional H_DN_R
// and H_DN_CMP. Each step waits on the registered data of the single read port
// of the heap memory. The presence map needs no clearing pass: a map bit is
// written 0 when its identifier is first issued, and returns at or above the
// fresh counter are ignored whatever the map holds.
// A result may wait in the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
module smallest_free_id_allocator #(
    parameter int ID_WIDTH    = 16,
    parameter int STORE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [sfid_pkg::IDENT_W-1:0]   i_ident,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sfid_pkg::IDENT_W-1:0]   o_taken_ident,
    output logic [sfid_pkg::STATUS_W-1:0]  o_status
);
    import sfid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAPRD,
        S_CHECK,
        S_WAIT,
        S_OUT
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [ID_WIDTH-1:0] r_id;
    logic [ID_WIDTH:0]   r_fresh;
    logic [ID_WIDTH-1:0] r_taken;
    t_status             r_status;
    logic                r_out_valid;
    logic [IDENT_W-1:0]  r_out_ident;
    t_status             r_out_status;

    logic                r_map [2**ID_WIDTH];
    logic                r_map_q;
    logic                map_we;
    logic [ID_WIDTH-1:0] map_wa;
    logic                map_wd;

    t_heap_req           heap_req;
    t_heap_rsp           heap_rsp;
    logic [ID_WIDTH-1:0] heap_top;

    logic                in_accept;
    logic                out_free;
    logic                ret_ignore;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ret_ignore = (r_id == '0) || ({1'b0, r_id} >= r_fresh) || r_map_q;

    sfid_heap #(
        .ID_WIDTH    (ID_WIDTH),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (heap_req),
        .i_value (r_id),
        .o_rsp   (heap_rsp),
        .o_top   (heap_top)
    );

    // map writes and heap requests
    always_comb begin
        map_we         = 1'b0;
        map_wa         = r_id;
        map_wd         = 1'b0;
        heap_req.start = 1'b0;
        heap_req.op    = HEAP_PUSH;
        case (r_state)
            S_CHECK: begin
                if (r_cmd == CMD_TAKE) begin
                    if (!heap_rsp.empty) begin
                        heap_req.start = 1'b1;
                        heap_req.op    = HEAP_POP;
                    end else if (!r_fresh[ID_WIDTH]) begin
                        // first issue of this identifier clears its map bit
                        map_we = 1'b1;
                        map_wa = r_fresh[ID_WIDTH-1:0];
                    end
                end else if (!ret_ignore && !heap_rsp.full) begin
                    heap_req.start = 1'b1;
                    map_we         = 1'b1;
                    map_wd         = 1'b1;
                end
            end
            S_WAIT: begin
                if (heap_rsp.done && (r_cmd == CMD_TAKE)) begin
                    map_we = 1'b1;
                    map_wa = heap_top;
                end
            end
            default: begin
                map_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_wa] <= map_wd;
        end
        r_map_q <= r_map[r_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fresh     <= (ID_WIDTH + 1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            // a result leaving while the next one loads is handled in S_OUT
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_id    <= ID_WIDTH'(i_ident);
                        r_state <= S_MAPRD;
                    end
                end
                S_MAPRD: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_taken <= '0;
                    r_state <= S_OUT;
                    if (r_cmd == CMD_TAKE) begin
                        if (!heap_rsp.empty) begin
                            r_status <= ST_TAKEN;
                            r_state  <= S_WAIT;
                        end else if (!r_fresh[ID_WIDTH]) begin
                            r_taken  <= r_fresh[ID_WIDTH-1:0];
                            r_status <= ST_TAKEN;
                            r_fresh  <= r_fresh + (ID_WIDTH + 1)'(1);
                        end else begin
                            r_status <= ST_EXHAUSTED;
                        end
                    end else if (ret_ignore) begin
                        r_status <= ST_IGNORED;
                    end else if (heap_rsp.full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status <= ST_RETURNED;
                        r_state  <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (heap_rsp.done) begin
                        if (r_cmd == CMD_TAKE) begin
                            r_taken <= heap_top;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_ident  <= IDENT_W'(r_taken);
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_taken_ident = r_out_ident;
    assign o_status      = r_out_status;

    a_done_only_when_waiting : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        heap_rsp.done |-> (r_state == S_WAIT)
    ) else $error("heap finished while no transaction was waiting on it");

    a_kept_return_not_empty : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && (r_status == ST_RETURNED)) |-> !heap_rsp.empty
    ) else $error("identifier kept on return but heap reads empty");

    a_zero_unless_taken : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_TAKEN)) |-> (r_out_ident == '0)
    ) else $error("non-zero identifier on a transaction that took nothing");

    a_fresh_nonzero : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_fresh != '0
    ) else $error("fresh counter wrapped to zero");

endmodule

/* rtl/sfid_heap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfid_heap
// Min-heap of returned identifiers in a single memory, sifted one level at a
// time by a small sequencer with one registered read port.
// ----------------------------------------------------------------------------
module sfid_heap #(
    parameter int ID_WIDTH    = 16,
    parameter int STORE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfid_pkg::t_heap_req i_req,
    input  logic [ID_WIDTH-1:0] i_value,
    output sfid_pkg::t_heap_rsp o_rsp,
    output logic [ID_WIDTH-1:0] o_top
);
    import sfid_pkg::*;

    localparam int IW  = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int CXW = IW + 2;

    typedef enum logic [3:0] {
        H_IDLE,
        H_UP_CHK,
        H_UP_CMP,
        H_DN_LAST,
        H_DN_SET,
        H_DN_C,
        H_DN_L,
        H_DN_R,
        H_DN_CMP
    } t_hstate;

    t_hstate             r_state;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_i;
    logic [IW-1:0]       r_ci;
    logic [ID_WIDTH-1:0] r_val;
    logic [ID_WIDTH-1:0] r_cv;
    logic [ID_WIDTH-1:0] r_top;
    logic                r_done;

    logic [ID_WIDTH-1:0] r_heap [STORE_DEPTH];
    logic [ID_WIDTH-1:0] r_rd_data;

    logic [IW-1:0]       up_idx;
    logic [CXW-1:0]      c_ext;
    logic [CXW-1:0]      c1_ext;
    logic [CXW-1:0]      cnt_ext;
    logic [IW-1:0]       rd_addr;
    logic                we;
    logic [IW-1:0]       wa;
    logic [ID_WIDTH-1:0] wd;

    assign up_idx  = (r_i - IW'(1)) >> 1;
    assign c_ext   = {1'b0, r_i, 1'b1};
    assign c1_ext  = c_ext + CXW'(1);
    assign cnt_ext = CXW'(r_count);

    // read address and write port per sequencer step
    always_comb begin
        rd_addr = '0;
        we      = 1'b0;
        wa      = r_i;
        wd      = r_val;
        case (r_state)
            H_UP_CHK: begin
                rd_addr = up_idx;
                if (r_i == '0) begin
                    we = 1'b1;
                end
            end
            H_UP_CMP: begin
                we = 1'b1;
                if (r_rd_data > r_val) begin
                    wd = r_rd_data;
                end
            end
            H_DN_LAST: begin
                rd_addr = IW'(r_count - CW'(1));
            end
            H_DN_C: begin
                rd_addr = c_ext[IW-1:0];
                if (c_ext >= cnt_ext) begin
                    we = 1'b1;
                end
            end
            H_DN_L: begin
                rd_addr = c1_ext[IW-1:0];
            end
            H_DN_CMP: begin
                we = 1'b1;
                if (r_val > r_cv) begin
                    wd = r_cv;
                end
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_heap[wa] <= wd;
        end
        r_rd_data <= r_heap[rd_addr];
    end

    // r_val holds the value being placed: the pushed one, or the last entry on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.op == HEAP_PUSH) begin
                            r_i     <= r_count[IW-1:0];
                            r_val   <= i_value;
                            r_count <= r_count + CW'(1);
                            r_state <= H_UP_CHK;
                        end else begin
                            r_state <= H_DN_LAST;
                        end
                    end
                end
                H_UP_CHK: begin
                    if (r_i == '0) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_state <= H_UP_CMP;
                    end
                end
                H_UP_CMP: begin
                    if (r_rd_data <= r_val) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_i     <= up_idx;
                        r_state <= H_UP_CHK;
                    end
                end
                H_DN_LAST: begin
                    r_top   <= r_rd_data;
                    r_state <= H_DN_SET;
                end
                H_DN_SET: begin
                    r_val   <= r_rd_data;
                    r_count <= r_count - CW'(1);
                    r_i     <= '0;
                    r_state <= H_DN_C;
                end
                H_DN_C: begin
                    if (c_ext >= cnt_ext) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_state <= H_DN_L;
                    end
                end
                H_DN_L: begin
                    r_cv <= r_rd_data;
                    r_ci <= c_ext[IW-1:0];
                    if (c1_ext < cnt_ext) begin
                        r_state <= H_DN_R;
                    end else begin
                        r_state <= H_DN_CMP;
                    end
                end
                H_DN_R: begin
                    if (r_rd_data < r_cv) begin
                        r_cv <= r_rd_data;
                        r_ci <= c1_ext[IW-1:0];
                    end
                    r_state <= H_DN_CMP;
                end
                H_DN_CMP: begin
                    if (r_val <= r_cv) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_i     <= r_ci;
                        r_state <= H_DN_C;
                    end
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.empty = (r_count == '0);
    assign o_rsp.full  = (r_count >= CW'(STORE_DEPTH));
    assign o_top       = r_top;

endmodule
